>>> src/sxf_pkg.sv
// Shared constants, request codes, state type and draw plan struct for the
// sprite XOR framebuffer. No dependencies; every other file depends on this package.
package sxf_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  // Field widths of the request and response words.
  localparam int REQ_W    = 2;
  localparam int XPOS_W   = 8;
  localparam int YPOS_W   = 8;
  localparam int ROW_W    = 4;
  localparam int SPRITE_W = 8;
  localparam int RLINE_W  = 5;
  localparam int PIX_W    = SCREEN_WIDTH;

  // Line index of the store, and the width of an unclipped line number
  // (y + row + x/64 reaches 273).
  localparam int LINE_W = $clog2(SCREEN_HEIGHT);
  localparam int YL_W   = 9;
  localparam int COL_W  = $clog2(SCREEN_WIDTH);

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINE0,
    ST_LINE1,
    ST_HOLD
  } sxf_state_t;

  // Decoded request: which lines to touch and the XOR masks for each.
  typedef struct packed {
    logic              is_clear;
    logic              is_draw;
    logic              is_read;
    logic              first;
    logic              ok0;
    logic              ok1;
    logic [LINE_W-1:0] addr0;
    logic [LINE_W-1:0] addr1;
    logic [PIX_W-1:0]  mask0;
    logic [PIX_W-1:0]  mask1;
  } sxf_plan_t;

endpackage

>>> src/sxf_if.sv
// Valid/ready channel interfaces for the sprite XOR framebuffer request and
// response words. Depends on sxf_pkg for the field widths.
interface sxf_req_if;
  logic                         valid;
  logic                         ready;
  logic [sxf_pkg::REQ_W-1:0]    req_type;
  logic [sxf_pkg::XPOS_W-1:0]   x_pos;
  logic [sxf_pkg::YPOS_W-1:0]   y_pos;
  logic [sxf_pkg::ROW_W-1:0]    row_offset;
  logic [sxf_pkg::SPRITE_W-1:0] sprite_row;
  logic                         first_row;
  logic [sxf_pkg::RLINE_W-1:0]  read_line;

  modport source(output valid, req_type, x_pos, y_pos, row_offset, sprite_row,
                 first_row, read_line, input ready);
  modport sink(input valid, req_type, x_pos, y_pos, row_offset, sprite_row,
               first_row, read_line, output ready);
endinterface

interface sxf_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      collision;
  logic [sxf_pkg::PIX_W-1:0] line_pixels;

  modport source(output valid, collision, line_pixels, input ready);
  modport sink(input valid, collision, line_pixels, output ready);
endinterface

>>> src/sprite_xor_framebuffer_unit.sv
// Sprite XOR framebuffer: 64x32 monochrome line store with XOR row drawing.
// A response word is registered at the end of the line-0 state after its request
// word is taken, or of the line-1 state for a draw whose sprite row spills into
// the next line. A new request is taken only in the idle state, once the last one
// has finished and its response has found the output register free; one store read and write per line.
// Reset: synchronous; all pixels off (per-line valid bits), collision flag clear.
module sprite_xor_framebuffer_unit import sxf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sxf_req_if.sink   req,
  sxf_rsp_if.source rsp
);

  sxf_state_t        st;
  sxf_state_t        st_next;
  sxf_plan_t         plan;
  sxf_plan_t         plan_q;
  logic              collision_flag;
  logic              flag_next;
  logic              out_valid;
  logic              out_collision;
  logic [PIX_W-1:0]  out_pixels;
  logic [PIX_W-1:0]  hold_pixels;
  logic [PIX_W-1:0]  res_pixels;
  logic              out_free;
  logic              accept;
  logic              finish;
  logic              clear_all;
  logic              rd_en;
  logic [LINE_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              wr_en;
  logic [LINE_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;

  // Decode the incoming word; the plan is captured when the word is taken.
  sxf_plan u_plan (
    .req_type  (req.req_type),
    .x_pos     (req.x_pos),
    .y_pos     (req.y_pos),
    .row_offset(req.row_offset),
    .sprite_row(req.sprite_row),
    .first_row (req.first_row),
    .read_line (req.read_line),
    .plan      (plan)
  );

  sxf_line_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .clear_all(clear_all),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;

  // Next state. A draw whose row spills over visits the second line; a result
  // that finds the output register full waits in the hold state.
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          st_next = ST_LINE0;
        end
      end
      ST_LINE0: begin
        if (plan_q.is_draw && plan_q.ok1) begin
          st_next = ST_LINE1;
        end else begin
          st_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_LINE1: begin
        st_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store accesses, flag update and result.
  // The first line is read in the cycle the word is taken; its data is
  // XORed and written back the next cycle for a draw while the spill line is read.
  always_comb begin
    req.ready  = 1'b0;
    clear_all  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = plan.addr0;
    wr_en      = 1'b0;
    wr_addr    = plan_q.addr0;
    wr_data    = rd_data ^ plan_q.mask0;
    flag_next  = collision_flag;
    finish     = 1'b0;
    res_pixels = '0;
    unique case (st)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          clear_all = plan.is_clear;
          rd_en     = plan.ok0;
        end
      end
      ST_LINE0: begin
        if (plan_q.is_draw) begin
          wr_en     = plan_q.ok0;
          flag_next = (collision_flag && !plan_q.first)
                      || (plan_q.ok0 && (|(rd_data & plan_q.mask0)));
          if (plan_q.ok1) begin
            rd_en   = 1'b1;
            rd_addr = plan_q.addr1;
          end else begin
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
          if (plan_q.is_read && plan_q.ok0) begin
            res_pixels = rd_data;
          end
        end
      end
      ST_LINE1: begin
        wr_en     = 1'b1;
        wr_addr   = plan_q.addr1;
        wr_data   = rd_data ^ plan_q.mask1;
        flag_next = collision_flag || (|(rd_data & plan_q.mask1));
        finish    = 1'b1;
      end
      ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      collision_flag <= 1'b0;
    end else begin
      st             <= st_next;
      collision_flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_q <= plan;
    end
  end

  // Response register, with a holding word for a result that finished while
  // the previous response was still waiting to be taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && out_free) begin
      out_valid <= 1'b1;
    end else if (st == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (out_free) begin
        out_collision <= flag_next;
        out_pixels    <= res_pixels;
      end else begin
        hold_pixels <= res_pixels;
      end
    end else if (st == ST_HOLD && out_free) begin
      out_collision <= collision_flag;
      out_pixels    <= hold_pixels;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.collision   = out_collision;
  assign rsp.line_pixels = out_pixels;

endmodule

>>> src/sxf_plan.sv
// Request decoder: turns one request word into line addresses and XOR masks.
// Depends on sxf_pkg.
module sxf_plan import sxf_pkg::*; (
  input  logic [REQ_W-1:0]    req_type,
  input  logic [XPOS_W-1:0]   x_pos,
  input  logic [YPOS_W-1:0]   y_pos,
  input  logic [ROW_W-1:0]    row_offset,
  input  logic [SPRITE_W-1:0] sprite_row,
  input  logic                first_row,
  input  logic [RLINE_W-1:0]  read_line,
  output sxf_plan_t           plan
);

  logic [YL_W-1:0]           line0;
  logic [YL_W-1:0]           line1;
  logic [YL_W-1:0]           rline;
  logic [PIX_W+SPRITE_W-1:0] wide;
  logic                      draw;
  logic                      rd;

  // A sprite row covers at most two stored lines: the part that fits in the
  // first line and the part that spills over the right edge into the next.
  assign line0 = YL_W'(y_pos) + YL_W'(row_offset) + YL_W'(x_pos[XPOS_W-1:COL_W]);
  assign line1 = line0 + YL_W'(1);
  assign rline = YL_W'(read_line);
  assign wide  = {sprite_row, {PIX_W{1'b0}}} >> x_pos[COL_W-1:0];
  assign draw  = (req_type == REQ_DRAW);
  assign rd    = (req_type == REQ_READ);

  always_comb begin
    plan.is_clear = (req_type == REQ_CLEAR);
    plan.is_draw  = draw;
    plan.is_read  = rd;
    plan.first    = first_row;
    plan.mask0    = wide[PIX_W+SPRITE_W-1:SPRITE_W];
    plan.mask1    = {wide[SPRITE_W-1:0], {(PIX_W-SPRITE_W){1'b0}}};
    plan.addr1    = line1[LINE_W-1:0];
    if (rd) begin
      plan.addr0 = rline[LINE_W-1:0];
      plan.ok0   = (rline < YL_W'(SCREEN_HEIGHT));
    end else begin
      plan.addr0 = line0[LINE_W-1:0];
      plan.ok0   = draw && (line0 < YL_W'(SCREEN_HEIGHT));
    end
    plan.ok1 = draw && (line1 < YL_W'(SCREEN_HEIGHT)) && (|wide[SPRITE_W-1:0]);
  end

endmodule

>>> src/sxf_line_ram.sv
// Line store: one 64-bit word per display line, one read and one write port,
// registered read data, per-line valid bits for reset and clear. Uses sxf_pkg.
module sxf_line_ram import sxf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear_all,
  input  logic              rd_en,
  input  logic [LINE_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [LINE_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data
);

  logic [PIX_W-1:0]         mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] line_valid;
  logic [PIX_W-1:0]         mem_q;
  logic                     valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // A line that has not been written since reset or the last clear reads as
  // all pixels off.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      line_valid <= '0;
    end else if (wr_en) begin
      line_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (rd_en) begin
      valid_q <= line_valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule
